// ===== hw/rtl/lrpb_pkg.sv =====
package lrpb_pkg;

  // default store geometry
  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;

  // fixed field widths
  localparam int X_W    = 7;
  localparam int Y_W    = 6;
  localparam int IDX_W  = 10;
  localparam int BYTE_W = 8;
  // row bits inside one page byte
  localparam int ROW_W  = 3;
  // bresenham error term, signed, wide enough for +-2*127
  localparam int ERR_W  = 10;

  // command codes
  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic step;
    logic pix_rd;
    logic pix_wr;
    logic byte_rd;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic octant_ok;
    logic last_pix;
  } dp_stat_t;

endpackage

// ===== hw/rtl/lrpb_frame_store.sv =====
module lrpb_frame_store #(
  parameter int DEPTH = lrpb_pkg::COLUMNS_DEF * lrpb_pkg::PAGES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [lrpb_pkg::BYTE_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [lrpb_pkg::BYTE_W-1:0] rdata_o
);

  logic [lrpb_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [lrpb_pkg::BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lrpb_datapath.sv =====
module lrpb_datapath #(
  parameter int COLUMNS = lrpb_pkg::COLUMNS_DEF,
  parameter int PAGES   = lrpb_pkg::PAGES_DEF,
  parameter int DEPTH   = COLUMNS * PAGES,
  parameter int AW      = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lrpb_pkg::dp_cmd_t           cmd_i,
  output lrpb_pkg::dp_stat_t          stat_o,
  input  logic [lrpb_pkg::X_W-1:0]    x_start_i,
  input  logic [lrpb_pkg::Y_W-1:0]    y_start_i,
  input  logic [lrpb_pkg::X_W-1:0]    x_end_i,
  input  logic [lrpb_pkg::Y_W-1:0]    y_end_i,
  input  logic [lrpb_pkg::IDX_W-1:0]  byte_index_i,
  output logic                        mem_we_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [lrpb_pkg::BYTE_W-1:0] mem_wdata_o,
  output logic                        mem_re_o,
  output logic [AW-1:0]               mem_raddr_o,
  input  logic [lrpb_pkg::BYTE_W-1:0] mem_rdata_i,
  output logic [lrpb_pkg::BYTE_W-1:0] read_byte_o
);

  localparam int ERR_W = lrpb_pkg::ERR_W;
  localparam int ROW_W = lrpb_pkg::ROW_W;

  logic [AW-1:0]                clr_q, clr_d;
  logic [lrpb_pkg::X_W-1:0]     x_q, x_end_q;
  logic [lrpb_pkg::Y_W-1:0]     y_q;
  logic signed [ERR_W-1:0]      err_q, dy2_q, dy2_dx2_q;
  logic                         octant_ok_q;
  logic [lrpb_pkg::IDX_W-1:0]   byte_index_q;
  logic                         rd_ok_q;

  logic [lrpb_pkg::X_W-1:0]     dx_u;
  logic [lrpb_pkg::Y_W-1:0]     dy_u;
  logic [ERR_W-1:0]             dx_ext, dy_ext;
  logic                         octant_ok_d;
  logic [lrpb_pkg::Y_W-ROW_W-1:0] page;
  logic                         on_store;
  logic [AW-1:0]                pix_addr;
  logic [lrpb_pkg::BYTE_W-1:0]  pix_mask;

  // clearing pass address
  assign clr_d = clr_q + AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_d;
    end
  end

  // line set-up from the command fields
  assign dx_u   = x_end_i - x_start_i;
  assign dy_u   = y_end_i - y_start_i;
  assign dx_ext = ERR_W'(dx_u);
  assign dy_ext = ERR_W'(dy_u);
  assign octant_ok_d = (x_end_i >= x_start_i) && (y_end_i >= y_start_i)
                       && (lrpb_pkg::X_W'(dy_u) <= dx_u);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q          <= x_start_i;
      y_q          <= y_start_i;
      x_end_q      <= x_end_i;
      err_q        <= $signed((dy_ext << 1) - dx_ext);
      dy2_q        <= $signed(dy_ext << 1);
      dy2_dx2_q    <= $signed((dy_ext << 1) - (dx_ext << 1));
      octant_ok_q  <= octant_ok_d;
      byte_index_q <= byte_index_i;
      rd_ok_q      <= (32'(byte_index_i) < DEPTH);
    end else if (cmd_i.step) begin
      x_q <= x_q + lrpb_pkg::X_W'(1);
      if (err_q > 0) begin
        y_q   <= y_q + lrpb_pkg::Y_W'(1);
        err_q <= err_q + dy2_dx2_q;
      end else begin
        err_q <= err_q + dy2_q;
      end
    end
  end

  // pixel address and bit
  assign page     = y_q[lrpb_pkg::Y_W-1:ROW_W];
  assign on_store = (32'(x_q) < COLUMNS) && (32'(page) < PAGES);
  assign pix_addr = AW'(32'(x_q) + COLUMNS * 32'(page));
  assign pix_mask = lrpb_pkg::BYTE_W'(1) << y_q[ROW_W-1:0];

  assign mem_we_o    = cmd_i.clr_step | (cmd_i.pix_wr & on_store);
  assign mem_waddr_o = cmd_i.clr_step ? clr_q : pix_addr;
  assign mem_wdata_o = cmd_i.clr_step ? '0 : (mem_rdata_i | pix_mask);
  assign mem_re_o    = (cmd_i.pix_rd & on_store) | (cmd_i.byte_rd & rd_ok_q);
  assign mem_raddr_o = cmd_i.byte_rd ? AW'(byte_index_q) : pix_addr;

  assign read_byte_o = rd_ok_q ? mem_rdata_i : '0;

  assign stat_o.clr_last  = (clr_q == AW'(DEPTH - 1));
  assign stat_o.octant_ok = octant_ok_q;
  assign stat_o.last_pix  = (x_q == x_end_q);

endmodule

// ===== hw/rtl/lrpb_ctrl.sv =====
module lrpb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               cmd_i,
  input  lrpb_pkg::dp_stat_t stat_i,
  output lrpb_pkg::dp_cmd_t  cmd_o,
  output logic               busy_o,
  output logic               read_valid_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RD_REQ = 3'd2;
  localparam logic [2:0] ST_RD_OUT = 3'd3;
  localparam logic [2:0] ST_CHK    = 3'd4;
  localparam logic [2:0] ST_PIX_RD = 3'd5;
  localparam logic [2:0] ST_PIX_WR = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    busy_o       = 1'b1;
    read_valid_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = (cmd_i == lrpb_pkg::CMD_READ) ? ST_RD_REQ : ST_CHK;
        end
      end
      ST_RD_REQ: begin
        cmd_o.byte_rd = 1'b1;
        state_d       = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        read_valid_o = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_CHK: begin
        state_d = stat_i.octant_ok ? ST_PIX_RD : ST_IDLE;
      end
      ST_PIX_RD: begin
        cmd_o.pix_rd = 1'b1;
        state_d      = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        cmd_o.pix_wr = 1'b1;
        if (stat_i.last_pix) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_PIX_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/line_raster_into_page_buffer_unit.sv =====
// read command: the read_valid_o strobe follows the start transfer through the RD_REQ and RD_OUT states
// draw command: each pixel is a
//   read-modify-write of one store byte over the single store read/write pair
// one command at a time, start is taken only while busy is low
// reset: the store is cleared by a pass over all COLUMNS*PAGES bytes (1024 by default)
//   with busy high; the receiver cannot stall the read_valid_o strobe
module line_raster_into_page_buffer_unit #(
  parameter int COLUMNS = lrpb_pkg::COLUMNS_DEF,
  parameter int PAGES   = lrpb_pkg::PAGES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cmd_i,
  input  logic [lrpb_pkg::X_W-1:0]    x_start_i,
  input  logic [lrpb_pkg::Y_W-1:0]    y_start_i,
  input  logic [lrpb_pkg::X_W-1:0]    x_end_i,
  input  logic [lrpb_pkg::Y_W-1:0]    y_end_i,
  input  logic [lrpb_pkg::IDX_W-1:0]  byte_index_i,
  output logic                        read_valid_o,
  output logic [lrpb_pkg::BYTE_W-1:0] read_byte_o
);

  // frame store geometry, byte address is column + COLUMNS * page
  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);

  lrpb_pkg::dp_cmd_t  dp_cmd;
  lrpb_pkg::dp_stat_t dp_stat;

  // store port wires
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [lrpb_pkg::BYTE_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [lrpb_pkg::BYTE_W-1:0] mem_rdata;

  // sequencer: clearing pass, read and per-pixel read-modify-write
  lrpb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .cmd_i        (cmd_i),
    .stat_i       (dp_stat),
    .cmd_o        (dp_cmd),
    .busy_o       (busy),
    .read_valid_o (read_valid_o)
  );

  // bresenham stepping, address generation and byte merge
  lrpb_datapath #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES),
    .DEPTH   (DEPTH),
    .AW      (AW)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .byte_index_i (byte_index_i),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .read_byte_o  (read_byte_o)
  );

  // page-organised frame store, registered read
  lrpb_frame_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // a read transfer gives its strobe in the RD_OUT state that follows RD_REQ
  a_read_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == lrpb_pkg::CMD_READ) |=> ##1 read_valid_o)
    else $error("read result strobe missing");

  // a draw gives no result strobe in the CHK state or in the state after CHK
  a_draw_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == lrpb_pkg::CMD_DRAW) |=> !read_valid_o ##1 !read_valid_o)
    else $error("result strobe after draw");

  // the store is never written while the unit is idle
  a_no_idle_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !mem_we)
    else $error("store write while idle");

  // the strobe lasts one cycle only
  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_valid_o |=> !read_valid_o)
    else $error("result strobe held");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lrpb_pkg::*;

  // store geometry as built by default
  localparam int COLUMNS     = COLUMNS_DEF;
  localparam int PAGES       = PAGES_DEF;
  localparam int STORE_BYTES = COLUMNS * PAGES;

  // random part of the run, and its tail with no idling
  localparam int RANDOM_CMDS = 530;
  localparam int STEADY_TAIL = 60;
  // long enough for the longest draw, so this covers anything still in flight
  localparam int DRAIN_CYCLES = 300;

  // one command as presented on the ports
  typedef struct {
    logic             cmd;
    logic [X_W-1:0]   x_start;
    logic [Y_W-1:0]   y_start;
    logic [X_W-1:0]   x_end;
    logic [Y_W-1:0]   y_end;
    logic [IDX_W-1:0] byte_index;
  } raster_cmd_t;

  // directed row: command plus an optional hand-written read value
  typedef struct {
    raster_cmd_t       c;
    bit                typed;
    logic [BYTE_W-1:0] typed_byte;
  } directed_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              cmd_i;
  logic [X_W-1:0]    x_start_i;
  logic [Y_W-1:0]    y_start_i;
  logic [X_W-1:0]    x_end_i;
  logic [Y_W-1:0]    y_end_i;
  logic [IDX_W-1:0]  byte_index_i;
  logic              read_valid_o;
  logic [BYTE_W-1:0] read_byte_o;

  // private image of the frame store, kept in step with every accepted draw
  logic [BYTE_W-1:0] frame_img [STORE_BYTES];
  // read bytes still owed by the block, oldest first
  logic [BYTE_W-1:0] owed_bytes [$];
  // store byte at the start of the latest draw, used to aim reads
  int                last_anchor;
  int                fail_count;
  directed_row_t     dir_rows [$];

  line_raster_into_page_buffer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .byte_index_i (byte_index_i),
    .read_valid_o (read_valid_o),
    .read_byte_o  (read_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // generous fixed limit: a few times the slowest legal run
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // set one pixel by or, pixels off the store are dropped
  function automatic void set_pixel(input int x, input int y);
    int page;
    page = y / 8;
    if (x >= COLUMNS || page >= PAGES) return;
    frame_img[x + COLUMNS * page] |= BYTE_W'(8'h01 << (y % 8));
  endfunction

  // bresenham walk, first octant only, anything else leaves the image alone
  function automatic void rasterise_line(input raster_cmd_t c);
    int x, y, dx, dy, err;
    if (c.x_end < c.x_start || c.y_end < c.y_start) return;
    dx = int'(c.x_end) - int'(c.x_start);
    dy = int'(c.y_end) - int'(c.y_start);
    if (dy > dx) return;
    x   = c.x_start;
    y   = c.y_start;
    err = 2 * dy - dx;
    set_pixel(x, y);
    while (x < int'(c.x_end)) begin
      if (err > 0) begin
        y++;
        err += 2 * dy - 2 * dx;
      end else begin
        err += 2 * dy;
      end
      x++;
      set_pixel(x, y);
    end
  endfunction

  function automatic logic [BYTE_W-1:0] stored_byte(input logic [IDX_W-1:0] idx);
    if (int'(idx) < STORE_BYTES) return frame_img[idx];
    return '0;
  endfunction

  function automatic raster_cmd_t mk_cmd(input logic cmd, input int xs, input int ys,
                                         input int xe, input int ye, input int idx);
    raster_cmd_t c;
    c.cmd        = cmd;
    c.x_start    = X_W'(xs);
    c.y_start    = Y_W'(ys);
    c.x_end      = X_W'(xe);
    c.y_end      = Y_W'(ye);
    c.byte_index = IDX_W'(idx);
    return c;
  endfunction

  function automatic void add_row(input raster_cmd_t c, input bit typed,
                                  input logic [BYTE_W-1:0] typed_byte);
    directed_row_t r;
    r.c          = c;
    r.typed      = typed;
    r.typed_byte = typed_byte;
    dir_rows.push_back(r);
  endfunction

  // random command: first-octant lines with random content, reads (some aimed
  // at freshly drawn bytes), and a share of fully random noise
  function automatic raster_cmd_t random_cmd();
    raster_cmd_t c;
    int sel, x0, y0, reach, dx, dy;
    sel = $urandom_range(0, 99);
    c = mk_cmd(CMD_DRAW, $urandom_range(0, 127), $urandom_range(0, 63),
               $urandom_range(0, 127), $urandom_range(0, 63), $urandom_range(0, 1023));
    if (sel < 40) begin
      c.cmd = CMD_READ;
      if ($urandom_range(0, 1) == 0) begin
        c.byte_index = IDX_W'(last_anchor + $urandom_range(0, 15));
      end
    end else if (sel < 85) begin
      // well-formed line, mostly short so the store does not fill up
      x0    = $urandom_range(0, 127);
      y0    = $urandom_range(0, 63);
      reach = ($urandom_range(0, 9) == 0) ? 127 : 15;
      dx    = $urandom_range(0, (127 - x0 < reach) ? 127 - x0 : reach);
      dy    = $urandom_range(0, (63 - y0 < dx) ? 63 - y0 : dx);
      c.x_start = X_W'(x0);
      c.y_start = Y_W'(y0);
      c.x_end   = X_W'(x0 + dx);
      c.y_end   = Y_W'(y0 + dy);
    end
    return c;
  endfunction

  // present one command, hold it until the transfer and then update the image or the owed reads
  task automatic issue(input raster_cmd_t c, input bit typed,
                       input logic [BYTE_W-1:0] typed_byte, input bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    cmd_i        <= c.cmd;
    x_start_i    <= c.x_start;
    y_start_i    <= c.y_start;
    x_end_i      <= c.x_end;
    y_end_i      <= c.y_end;
    byte_index_i <= c.byte_index;
    // start is high at every edge from here, so busy low marks the transfer
    do @(posedge clk_i); while (busy);
    if (c.cmd == CMD_DRAW) begin
      rasterise_line(c);
      last_anchor = int'(c.x_start) + COLUMNS * (int'(c.y_start) / 8);
    end else begin
      owed_bytes.push_back(typed ? typed_byte : stored_byte(c.byte_index));
    end
  endtask

  // result side: the strobe lasts one cycle and cannot be held off
  always @(posedge clk_i) begin
    if (rst_ni && read_valid_o) begin
      if (owed_bytes.size() == 0) begin
        $error("read_byte: no read outstanding, actual 0x%02h", read_byte_o);
        fail_count++;
      end else begin
        if (read_byte_o !== owed_bytes[0]) begin
          $error("read_byte: expected 0x%02h, actual 0x%02h", owed_bytes[0], read_byte_o);
          fail_count++;
        end
        void'(owed_bytes.pop_front());
      end
    end
  end

  initial begin
    fail_count  = 0;
    last_anchor = 0;
    foreach (frame_img[i]) frame_img[i] = '0;

    // every input known from time zero
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    cmd_i        <= CMD_DRAW;
    x_start_i    <= '0;
    y_start_i    <= '0;
    x_end_i      <= '0;
    y_end_i      <= '0;
    byte_index_i <= '0;

    // directed table: store empty after reset, corner pixels, lines outside the first
    // octant, short and diagonal lines, then full-width lines
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 0), 1'b1, 8'h00);
    add_row(mk_cmd(CMD_READ, 127, 63, 127, 63, 1023), 1'b1, 8'h00);
    add_row(mk_cmd(CMD_DRAW, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 0), 1'b1, 8'h01);
    add_row(mk_cmd(CMD_DRAW, 127, 63, 127, 63, 1023), 1'b0, '0);
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 1023), 1'b1, 8'h80);
    // end column left of start
    add_row(mk_cmd(CMD_DRAW, 10, 5, 5, 5, 0), 1'b0, '0);
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 5), 1'b1, 8'h00);
    // end row above start
    add_row(mk_cmd(CMD_DRAW, 20, 10, 30, 5, 0), 1'b0, '0);
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 148), 1'b1, 8'h00);
    // too steep
    add_row(mk_cmd(CMD_DRAW, 40, 0, 41, 10, 0), 1'b0, '0);
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 40), 1'b1, 8'h00);
    // one step right and down, one step right only
    add_row(mk_cmd(CMD_DRAW, 50, 8, 51, 9, 0), 1'b0, '0);
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 178), 1'b0, '0);
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 179), 1'b0, '0);
    add_row(mk_cmd(CMD_DRAW, 60, 16, 61, 16, 0), 1'b0, '0);
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 317), 1'b0, '0);
    // 45 degree diagonal, full-width flat line, full-width shallow line
    add_row(mk_cmd(CMD_DRAW, 64, 0, 127, 63, 0), 1'b0, '0);
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 100 + 128 * 4), 1'b0, '0);
    add_row(mk_cmd(CMD_DRAW, 0, 32, 127, 32, 0), 1'b0, '0);
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 512), 1'b0, '0);
    add_row(mk_cmd(CMD_DRAW, 0, 0, 127, 63, 1023), 1'b0, '0);
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 64 + 128 * 4), 1'b0, '0);
    add_row(mk_cmd(CMD_READ, 0, 0, 0, 0, 1023), 1'b0, '0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows with random idle gaps, the clearing pass after reset shows up as busy
    foreach (dir_rows[i]) begin
      issue(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].typed_byte, 1'b1);
    end

    // random part, idle gaps stop for the final stretch
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      issue(random_cmd(), 1'b0, '0, n < RANDOM_CMDS - STEADY_TAIL);
    end
    start <= 1'b0;

    // let outstanding reads land, then give a trailing draw time to finish
    wait (owed_bytes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lrpb_pkg.sv
hw/rtl/lrpb_frame_store.sv
hw/rtl/lrpb_datapath.sv
hw/rtl/lrpb_ctrl.sv
hw/rtl/line_raster_into_page_buffer_unit.sv
tb/sv/tb_top.sv
